>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a plain condition on every clock edge outside reset.
`define BPAL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

>>> design/bpal_pkg.sv
`default_nettype none
package bpal_pkg;

  localparam int unsigned SAMPLES_DEF  = 20;
  localparam int unsigned MAX_VERT_DEF = 512;
  localparam int unsigned CW = 16;   // coordinate width
  localparam int unsigned DW = 24;   // distance width
  localparam int unsigned WW = 17;   // Bernstein weight width, Q0.16 up to 1.0

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef struct packed {
    cmd_t                 op;
    logic signed [CW-1:0] p0_x;
    logic signed [CW-1:0] p0_y;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] p3_x;
    logic signed [CW-1:0] p3_y;
    logic [DW-1:0]        qdist;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAC,
    ST_RND,
    ST_APP,
    ST_SQI,
    ST_SQRT,
    ST_WR,
    ST_QCHK,
    ST_SRCH,
    ST_SCMP,
    ST_QR0,
    ST_QR1,
    ST_QR2,
    ST_QDIV,
    ST_QLX,
    ST_QLY,
    ST_QEND,
    ST_DONE
  } eng_state_t;

  // Bernstein weight k at parameter t (Q0.16), rounded half up
  function automatic logic [WW-1:0] bern_weight(input longint unsigned t,
                                                input int unsigned k);
    longint unsigned u;
    longint unsigned v;
    u = 64'd65536 - t;
    case (k)
      0:       v = u * u * u;
      1:       v = 64'd3 * u * u * t;
      2:       v = 64'd3 * u * t * t;
      default: v = t * t * t;
    endcase
    v = (v + 64'h8000_0000) >> 32;
    return v[WW-1:0];
  endfunction

  // Round a Q16 product half up, add a base and saturate to 16 bits
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [35:0] acc,
                                                   input logic signed [CW-1:0] base);
    logic signed [35:0]   sh;
    logic signed [36:0]   sum;
    logic signed [CW-1:0] res;
    sh  = (acc + 36'sd32768) >>> 16;
    sum = 37'(sh) + 37'(base);
    if (sum > 37'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -37'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[CW-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/bpal_if.sv
`default_nettype none
interface bpal_in_if import bpal_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic signed [CW-1:0] p0_x;
  logic signed [CW-1:0] p0_y;
  logic signed [CW-1:0] p1_x;
  logic signed [CW-1:0] p1_y;
  logic signed [CW-1:0] p2_x;
  logic signed [CW-1:0] p2_y;
  logic signed [CW-1:0] p3_x;
  logic signed [CW-1:0] p3_y;
  logic [DW-1:0]        query_distance;

  modport source (output valid, cmd, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  query_distance, input ready);
  modport sink   (input valid, cmd, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  query_distance, output ready);
endinterface

interface bpal_out_if import bpal_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic [1:0]           status;

  modport source (output valid, pos_x, pos_y, status, input ready);
  modport sink   (input valid, pos_x, pos_y, status, output ready);
endinterface
`default_nettype wire

>>> design/bpal_front.sv
`default_nettype none
module bpal_front import bpal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bpal_in_if.sink    in_ch,
  output logic       hd_valid,
  input  logic       hd_ready,
  output item_t      hd_item
);

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push, pop;

  // classify the incoming beat
  always_comb begin
    cls       = '0;
    unique case (in_ch.cmd)
      2'd0:    cls.op = CMD_CLEAR;
      2'd1:    cls.op = CMD_ADD;
      2'd2:    cls.op = CMD_CLOSE;
      default: cls.op = CMD_QUERY;
    endcase
    cls.p0_x  = in_ch.p0_x;
    cls.p0_y  = in_ch.p0_y;
    cls.p1_x  = in_ch.p1_x;
    cls.p1_y  = in_ch.p1_y;
    cls.p2_x  = in_ch.p2_x;
    cls.p2_y  = in_ch.p2_y;
    cls.p3_x  = in_ch.p3_x;
    cls.p3_y  = in_ch.p3_y;
    cls.qdist = in_ch.query_distance;
  end

  assign in_ch.ready = !cnt_r[1];
  assign push        = in_ch.valid && in_ch.ready;
  assign hd_valid    = (cnt_r != 2'd0);
  assign pop         = hd_valid && hd_ready;
  assign hd_item     = ent_r[rp_r];

  // hold items in a two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> design/bpal_back.sv
`default_nettype none
`include "assert_macros.svh"
module bpal_back import bpal_pkg::*; #(
  parameter int unsigned SAMPLES_PER_SEGMENT = SAMPLES_DEF,
  parameter int unsigned MAX_VERTICES        = MAX_VERT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hd_valid,
  output logic       hd_ready,
  input  item_t      hd_item,
  bpal_out_if.source out_ch
);

  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned SW   = (SAMPLES_PER_SEGMENT > 1) ? $clog2(SAMPLES_PER_SEGMENT) : 1;
  localparam int unsigned FW   = CNTW + 8;
  localparam int unsigned MW   = 2 * CW + DW;
  localparam logic [SW-1:0] SAMP_LAST = SW'(SAMPLES_PER_SEGMENT - 1);

  // Bernstein weight table, one row per sample
  logic [WW-1:0] wt [SAMPLES_PER_SEGMENT][4];
  for (genvar gi = 0; gi < SAMPLES_PER_SEGMENT; gi++) begin : g_wt
    localparam longint unsigned TV = (64'(gi) * 64'd65536) / SAMPLES_PER_SEGMENT;
    for (genvar gk = 0; gk < 4; gk++) begin : g_k
      assign wt[gi][gk] = bern_weight(TV, gk);
    end
  end

  eng_state_t           st_r, st_nxt;
  item_t                item_r;
  logic [CNTW-1:0]      count_r;
  logic [DW-1:0]        path_r;
  logic signed [CW-1:0] last_x_r, last_y_r, prev_x_r, prev_y_r;
  logic                 has_seg_r;
  logic [SW-1:0]        samp_r;
  logic [2:0]           mac_r;
  logic signed [35:0]   acc_x_r, acc_y_r;
  logic signed [CW-1:0] nx_r, ny_r;
  logic [33:0]          sqx_r, sqy_r;
  logic [35:0]          sq_rem_r, sq_res_r, sq_bit_r;
  logic [CNTW-1:0]      lo_r, hi_r, mid_r;
  logic signed [CW-1:0] v0_x_r, v0_y_r, v1_x_r, v1_y_r;
  logic [DW-1:0]        v0_d_r;
  logic [DW:0]          dv_rem_r;
  logic [DW-1:0]        dv_den_r;
  logic [4:0]           dv_cnt_r;
  logic [WW-1:0]        quot_r;
  logic signed [CW-1:0] pend_x_r, pend_y_r;
  stat_t                pend_st_r;
  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  stat_t                out_st_r;

  logic [MW-1:0]        mem [MAX_VERTICES];
  logic [MW-1:0]        rd_q;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic                 out_free;
  logic                 out_load;

  // decode of the current state and operands
  logic signed [CW-1:0] pxs [4];
  logic signed [CW-1:0] pys [4];
  logic [1:0]           mk;
  logic signed [CW-1:0] mpt;
  logic signed [33:0]   mprod;
  logic signed [CW:0]   dx, dy, dl;
  logic signed [33:0]   sqx, sqy;
  logic [35:0]          sq_trial;
  logic [DW:0]          psum;
  logic [DW-1:0]        pnew;
  logic [DW-1:0]        rd_d;
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 dv_ge;
  logic [DW:0]          dv_diff;
  logic signed [34:0]   lprod;
  logic [CNTW:0]        mid_w;
  logic                 fits;
  logic                 seg_last;

  assign pxs[0] = item_r.p0_x;
  assign pxs[1] = item_r.p1_x;
  assign pxs[2] = item_r.p2_x;
  assign pxs[3] = item_r.p3_x;
  assign pys[0] = item_r.p0_y;
  assign pys[1] = item_r.p1_y;
  assign pys[2] = item_r.p2_y;
  assign pys[3] = item_r.p3_y;

  assign mk       = mac_r[1:0];
  assign mpt      = mac_r[2] ? pys[mk] : pxs[mk];
  assign mprod    = $signed({1'b0, wt[samp_r][mk]}) * mpt;
  assign dx       = (CW+1)'(nx_r) - (CW+1)'(prev_x_r);
  assign dy       = (CW+1)'(ny_r) - (CW+1)'(prev_y_r);
  assign sqx      = dx * dx;
  assign sqy      = dy * dy;
  assign sq_trial = sq_res_r + sq_bit_r;
  assign psum     = (DW+1)'(path_r) + (DW+1)'(sq_res_r[17:0]);
  assign pnew     = psum[DW] ? {DW{1'b1}} : psum[DW-1:0];
  assign rd_x     = rd_q[MW-1 -: CW];
  assign rd_y     = rd_q[DW +: CW];
  assign rd_d     = rd_q[DW-1:0];
  assign dv_ge    = dv_rem_r >= {1'b0, dv_den_r};
  assign dv_diff  = dv_ge ? (dv_rem_r - {1'b0, dv_den_r}) : dv_rem_r;
  assign dl       = (st_r == ST_QLY) ? ((CW+1)'(v1_y_r) - (CW+1)'(v0_y_r))
                                     : ((CW+1)'(v1_x_r) - (CW+1)'(v0_x_r));
  assign lprod    = dl * $signed({1'b0, quot_r});
  assign mid_w    = ((CNTW+1)'(lo_r) + (CNTW+1)'(hi_r)) >> 1;
  assign fits     = (FW'(count_r) + FW'(SAMPLES_PER_SEGMENT)) <= FW'(MAX_VERTICES);
  assign seg_last = (samp_r == SAMP_LAST);
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (hd_valid) begin
          unique case (hd_item.op)
            CMD_CLEAR: st_nxt = ST_DONE;
            CMD_ADD:   st_nxt = fits ? ST_MAC : ST_DONE;
            CMD_CLOSE: st_nxt = (has_seg_r && (count_r < CNTW'(MAX_VERTICES))) ? ST_APP
                                                                               : ST_DONE;
            default:   st_nxt = ST_QCHK;
          endcase
        end
      end
      ST_MAC:  st_nxt = (mac_r == 3'd7) ? ST_RND : ST_MAC;
      ST_RND:  st_nxt = ST_APP;
      ST_APP:  st_nxt = (count_r == '0) ? ST_WR : ST_SQI;
      ST_SQI:  st_nxt = ST_SQRT;
      ST_SQRT: st_nxt = sq_bit_r[0] ? ST_WR : ST_SQRT;
      ST_WR:   st_nxt = ((item_r.op == CMD_ADD) && !seg_last) ? ST_MAC : ST_DONE;
      ST_QCHK: begin
        if (count_r == '0) begin
          st_nxt = ST_DONE;
        end else if ((item_r.qdist == '0) || (item_r.qdist >= path_r)) begin
          st_nxt = ST_QEND;
        end else begin
          st_nxt = ST_SRCH;
        end
      end
      ST_SRCH: st_nxt = (lo_r < hi_r) ? ST_SCMP : ST_QR0;
      ST_SCMP: st_nxt = ST_SRCH;
      ST_QR0:  st_nxt = ST_QR1;
      ST_QR1:  st_nxt = ST_QR2;
      ST_QR2:  st_nxt = ST_QDIV;
      ST_QDIV: st_nxt = (dv_cnt_r == 5'd16) ? ST_QLX : ST_QDIV;
      ST_QLX:  st_nxt = ST_QLY;
      ST_QLY:  st_nxt = ST_DONE;
      ST_QEND: st_nxt = ST_DONE;
      ST_DONE: st_nxt = out_free ? ST_IDLE : ST_DONE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // state outputs: queue pop, memory port, result load
  always_comb begin
    hd_ready = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: hd_ready = 1'b1;
      ST_WR:   mem_we   = 1'b1;
      ST_QCHK: begin
        if (item_r.qdist != '0) begin
          rd_addr = AW'(count_r - 1'b1);
        end
      end
      ST_SRCH: rd_addr = AW'(mid_w);
      ST_QR0:  rd_addr = AW'(lo_r - 1'b1);
      ST_QR1:  rd_addr = AW'(lo_r);
      ST_DONE: out_load = out_free;
      default: rd_addr = '0;
    endcase
  end

  // vertex memory: x, y and distance in one word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(count_r)] <= {nx_r, ny_r, pnew};
    end
    rd_q <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      path_r      <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      has_seg_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((st_r == ST_IDLE) && hd_valid && (hd_item.op == CMD_CLEAR)) begin
        count_r   <= '0;
        path_r    <= '0;
        last_x_r  <= '0;
        last_y_r  <= '0;
        has_seg_r <= 1'b0;
      end
      if (st_r == ST_WR) begin
        count_r <= count_r + 1'b1;
        path_r  <= pnew;
        if (item_r.op == CMD_CLOSE) begin
          has_seg_r <= 1'b0;
        end else if (seg_last) begin
          last_x_r  <= item_r.p3_x;
          last_y_r  <= item_r.p3_y;
          has_seg_r <= 1'b1;
        end
      end
    end
  end

  // datapath: sampling, square root, search, divide, interpolate
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        item_r    <= hd_item;
        samp_r    <= '0;
        mac_r     <= '0;
        acc_x_r   <= '0;
        acc_y_r   <= '0;
        pend_x_r  <= '0;
        pend_y_r  <= '0;
        pend_st_r <= STAT_OK;
        nx_r      <= last_x_r;
        ny_r      <= last_y_r;
        if ((hd_item.op == CMD_ADD) && !fits) begin
          pend_st_r <= STAT_FULL;
        end
        if ((hd_item.op == CMD_CLOSE) && has_seg_r && (count_r >= CNTW'(MAX_VERTICES))) begin
          pend_st_r <= STAT_FULL;
        end
      end
      ST_MAC: begin
        mac_r <= mac_r + 3'd1;
        if (mac_r[2]) begin
          acc_y_r <= acc_y_r + 36'(mprod);
        end else begin
          acc_x_r <= acc_x_r + 36'(mprod);
        end
      end
      ST_RND: begin
        nx_r <= rnd_sat(acc_x_r, '0);
        ny_r <= rnd_sat(acc_y_r, '0);
      end
      ST_APP: begin
        sqx_r    <= sqx[33:0];
        sqy_r    <= sqy[33:0];
        sq_res_r <= '0;
      end
      ST_SQI: begin
        sq_rem_r <= 36'(sqx_r) + 36'(sqy_r);
        sq_res_r <= '0;
        sq_bit_r <= 36'd1 << 34;
      end
      ST_SQRT: begin
        if (sq_rem_r >= sq_trial) begin
          sq_rem_r <= sq_rem_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_WR: begin
        prev_x_r <= nx_r;
        prev_y_r <= ny_r;
        samp_r   <= samp_r + 1'b1;
        mac_r    <= '0;
        acc_x_r  <= '0;
        acc_y_r  <= '0;
      end
      ST_QCHK: begin
        lo_r <= '0;
        hi_r <= count_r;
        if (count_r == '0) begin
          pend_st_r <= STAT_EMPTY;
        end
      end
      ST_SRCH: mid_r <= CNTW'(mid_w);
      ST_SCMP: begin
        if (rd_d < item_r.qdist) begin
          lo_r <= mid_r + 1'b1;
        end else begin
          hi_r <= mid_r;
        end
      end
      ST_QR1: begin
        v0_x_r <= rd_x;
        v0_y_r <= rd_y;
        v0_d_r <= rd_d;
      end
      ST_QR2: begin
        v1_x_r   <= rd_x;
        v1_y_r   <= rd_y;
        dv_den_r <= rd_d - v0_d_r;
        dv_rem_r <= {1'b0, item_r.qdist - v0_d_r};
        dv_cnt_r <= '0;
        quot_r   <= '0;
      end
      ST_QDIV: begin
        quot_r   <= {quot_r[WW-2:0], dv_ge};
        dv_rem_r <= {dv_diff[DW-1:0], 1'b0};
        dv_cnt_r <= dv_cnt_r + 5'd1;
      end
      ST_QLX:  pend_x_r <= rnd_sat(36'(lprod), v0_x_r);
      ST_QLY:  pend_y_r <= rnd_sat(36'(lprod), v0_y_r);
      ST_QEND: begin
        pend_x_r <= rd_x;
        pend_y_r <= rd_y;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r  <= pend_x_r;
      out_y_r  <= pend_y_r;
      out_st_r <= pend_st_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.pos_x  = out_x_r;
  assign out_ch.pos_y  = out_y_r;
  assign out_ch.status = out_st_r;

  `BPAL_ASSERT(a_wr_room, mem_we |-> (count_r < CNTW'(MAX_VERTICES)), "write past table end")
  `BPAL_ASSERT(a_path_mono, (st_r != ST_IDLE) |=> (path_r >= $past(path_r)), "path shrank")
  `BPAL_ASSERT_ALWAYS(a_srch_rng, (st_r != ST_SCMP) || (lo_r < hi_r), "search out of range")
  `BPAL_ASSERT_ALWAYS(a_ratio_max, (st_r != ST_QLX) || (quot_r <= 17'd65536), "ratio above one")

endmodule
`default_nettype wire

>>> design/bezier_path_arc_length_lookup.sv
// Channel  Dir  Beat content
// in_ch    in   cmd, p0..p3 x/y (Q10.6), query_distance (Q18.6)
// out_ch   out  pos_x, pos_y (Q10.6), status
// Close takes one square root. Add segment takes 8 multiply-accumulates plus an
// 18-step square root per sample. Query runs a binary search with memory reads and
// the 17-step divider. rst_n is synchronous; one result register lets the next
// beats queue while a result waits.
`default_nettype none
module bezier_path_arc_length_lookup import bpal_pkg::*; #(
  parameter int unsigned SAMPLES_PER_SEGMENT = SAMPLES_DEF,
  parameter int unsigned MAX_VERTICES        = MAX_VERT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bpal_in_if.sink    in_ch,
  bpal_out_if.source out_ch
);

  logic  hd_valid;
  logic  hd_ready;
  item_t hd_item;

  // accept and classify beats
  bpal_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .hd_valid (hd_valid),
    .hd_ready (hd_ready),
    .hd_item  (hd_item)
  );

  // execute commands on the vertex table
  bpal_back #(
    .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT),
    .MAX_VERTICES        (MAX_VERTICES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hd_valid (hd_valid),
    .hd_ready (hd_ready),
    .hd_item  (hd_item),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
